// ----- sv/bfd_pkg.sv -----
// Package for the bit-coded field decoder: command codes, stage record types,
// a shared constant and a byte-order helper. No dependencies.
`default_nettype none
package bfd_pkg;

    typedef enum logic [3:0] {
        CMD_BIT     = 4'd0,
        CMD_BB      = 4'd1,
        CMD_3B      = 4'd2,
        CMD_4B      = 4'd3,
        CMD_RC      = 4'd4,
        CMD_RS      = 4'd5,
        CMD_RL      = 4'd6,
        CMD_RD      = 4'd7,
        CMD_BS      = 4'd8,
        CMD_BL      = 4'd9,
        CMD_BD      = 4'd10,
        CMD_DD      = 4'd11,
        CMD_MC      = 4'd12,
        CMD_UMC     = 4'd13,
        CMD_MS      = 4'd14,
        CMD_NONE    = 4'd15
    } t_cmd;

    localparam logic [63:0] DOUBLE_ONE = 64'h3FF0_0000_0000_0000;

    // Item as classified by the front part: window aligned to the field start.
    typedef struct packed {
        t_cmd        cmd;
        logic [1:0]  code;
        logic [73:0] bits;    // stream bits from the field start, first bit at MSB
        logic [63:0] dflt;
    } t_item;

    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  bits_used;
        logic        bad_code;
    } t_res;

    // Reassemble eight bytes stored first-byte-high into little-endian order.
    function automatic logic [63:0] le64(input logic [63:0] b);
        logic [63:0] r;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = b[63-8*k -: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/bfd_front.sv -----
// Front part: accepts items, aligns the window to the bit offset and queues them.
// Depends on bfd_pkg.
`default_nettype none
module bfd_front import bfd_pkg::*; #(
    parameter int Depth = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [3:0]  i_command,
    input  wire logic [2:0]  i_bit_offset,
    input  wire logic [15:0] i_window_head,
    input  wire logic [63:0] i_window_tail,
    input  wire logic [63:0] i_default_value,
    output logic             o_valid,
    input  wire logic        i_take,
    output t_item            o_item
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    t_item           q_mem [Depth];
    logic [Aw-1:0]   r_wp, r_rp, n_wp, n_rp;
    logic [Aw:0]     r_cnt, n_cnt;
    logic [79:0]     win;
    logic [79:0]     sh;
    t_item           cls;
    logic            do_push, do_pop;

    // Align the window and pick out the prefix code.
    always_comb begin
        win           = {i_window_head, i_window_tail};
        sh            = win << i_bit_offset;
        cls.cmd       = t_cmd'(i_command);
        cls.code      = sh[79:78];
        cls.bits      = sh[79:6];
        cls.dflt      = i_default_value;
    end

    assign o_full  = (r_cnt == (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_valid;
    assign o_item  = q_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == Aw'(Depth-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == Aw'(Depth-1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end

    // Store classified items.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            q_mem[r_wp] <= cls;
        end
    end

    // Advance pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Aw+1)'(Depth)) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !do_pop |=> o_full) else $error("full dropped without pop");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("push lost");
endmodule
`default_nettype wire

// ----- sv/bfd_back.sv -----
// Back part: decodes one aligned item and holds the result for the consumer.
// Depends on bfd_pkg.
`default_nettype none
module bfd_back import bfd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_take,
    input  wire t_item i_item,
    output logic       o_empty,
    input  wire logic  i_pop,
    output t_res       o_res
);
    t_res        res;
    logic        r_vld;
    t_res        r_res;
    logic [73:0] b;
    logic [63:0] w0, w2, mc;
    logic [7:0]  byt [8];
    logic [2:0]  last;
    logic        found;
    logic [14:0] ms0, ms1;

    assign b  = i_item.bits;
    assign w0 = le64(b[73:10]);
    assign w2 = le64(b[71:8]);

    // Find the last modular-char byte and assemble the modular value.
    always_comb begin
        for (int n = 0; n < 8; n++) begin
            byt[n] = b[73-8*n -: 8];
        end
        last  = 3'd7;
        found = 1'b0;
        for (int n = 0; n < 8; n++) begin
            if (!found && !byt[n][7]) begin
                last  = 3'(n);
                found = 1'b1;
            end
        end
        mc = '0;
        for (int n = 0; n < 8; n++) begin
            if (3'(n) < last) begin
                mc[7*n +: 7] = byt[n][6:0];
            end else if (3'(n) == last) begin
                mc[7*n +: 7] = (i_item.cmd == CMD_MC) ? {1'b0, byt[n][5:0]}
                                                      : byt[n][6:0];
            end
        end
        if (i_item.cmd == CMD_MC && byt[last][6]) begin
            mc = '0 - mc;
        end
    end

    assign ms0 = w0[14:0];
    assign ms1 = w0[30:16];

    // Decode by command.
    always_comb begin
        res = '0;
        unique case (i_item.cmd)
            CMD_BIT: begin res.value = 64'(b[73]); res.bits_used = 7'd1; end
            CMD_BB:  begin res.value = 64'(b[73:72]); res.bits_used = 7'd2; end
            CMD_3B:  begin res.value = 64'(b[73:71]); res.bits_used = 7'd3; end
            CMD_4B:  begin res.value = 64'(b[73:70]); res.bits_used = 7'd4; end
            CMD_RC:  begin res.value = 64'(b[73:66]); res.bits_used = 7'd8; end
            CMD_RS: begin
                res.value = {{48{w0[15]}}, w0[15:0]}; res.bits_used = 7'd16;
            end
            CMD_RL: begin
                res.value = {{32{w0[31]}}, w0[31:0]}; res.bits_used = 7'd32;
            end
            CMD_RD: begin res.value = w0; res.bits_used = 7'd64; end
            CMD_BS: begin
                unique case (i_item.code)
                    2'd0: begin
                        res.value = {{48{w2[15]}}, w2[15:0]}; res.bits_used = 7'd18;
                    end
                    2'd1: begin res.value = 64'(b[71:64]); res.bits_used = 7'd10; end
                    2'd2: res.bits_used = 7'd2;
                    default: begin res.value = 64'd256; res.bits_used = 7'd2; end
                endcase
            end
            CMD_BL: begin
                unique case (i_item.code)
                    2'd0: begin
                        res.value = {{32{w2[31]}}, w2[31:0]}; res.bits_used = 7'd34;
                    end
                    2'd1: begin res.value = 64'(b[71:64]); res.bits_used = 7'd10; end
                    2'd2: res.bits_used = 7'd2;
                    default: begin res.bits_used = 7'd2; res.bad_code = 1'b1; end
                endcase
            end
            CMD_BD: begin
                unique case (i_item.code)
                    2'd0: begin res.value = w2; res.bits_used = 7'd66; end
                    2'd1: begin res.value = DOUBLE_ONE; res.bits_used = 7'd2; end
                    default: res.bits_used = 7'd2;
                endcase
            end
            CMD_DD: begin
                unique case (i_item.code)
                    2'd0: begin res.value = i_item.dflt; res.bits_used = 7'd2; end
                    2'd1: begin
                        res.value = {i_item.dflt[63:32], w2[31:0]};
                        res.bits_used = 7'd34;
                    end
                    2'd2: begin
                        // low word: four bytes after the middle pair, little-endian
                        res.value = {i_item.dflt[63:48], w2[15:0],
                                     b[31:24], b[39:32], b[47:40], b[55:48]};
                        res.bits_used = 7'd50;
                    end
                    default: begin res.value = w2; res.bits_used = 7'd66; end
                endcase
            end
            CMD_MC, CMD_UMC: begin
                res.value     = mc;
                res.bits_used = {1'b0, last, 3'b000} + 7'd8;
            end
            CMD_MS: begin
                if (w0[15]) begin
                    res.value = 64'({ms1, ms0}); res.bits_used = 7'd32;
                end else begin
                    res.value = 64'(w0[15:0]); res.bits_used = 7'd16;
                end
            end
            default: res = '0;
        endcase
    end

    assign o_take  = i_valid && (!r_vld || i_pop);
    assign o_empty = !r_vld;
    assign o_res   = r_res;

    // Hold the result until popped.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= 1'b1;
        end else if (i_pop) begin
            r_vld <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_pop |=> r_vld && $stable(r_res)) else $error("result lost");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.bad_code |-> res.value == '0 && res.bits_used == 7'd2)
        else $error("bad code result");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> i_valid) else $error("take without item");
endmodule
`default_nettype wire

// ----- sv/bitcoded_field_decoder_core.sv -----
// Top level of the bit-coded field decoder: front queue plus decode back end.
// Depends on bfd_pkg, bfd_front, bfd_back.
//
//  channel  | direction | handshake     | fields
//  input    | in        | push / full   | command bit_offset window_head window_tail default_value
//  result   | out       | pop / empty   | value bits_used bad_code
//
// One item per cycle sustained while the result side pops. An accepted beat is written into
// the queue, then decoded into the result register once it is free, and is popped from there.
// The result register frees as it is popped, so the queue drains one item per pop.
// Synchronous active-low reset empties queue and result.
// A stalled result side fills the queue, then full rises.
`default_nettype none
module bitcoded_field_decoder_core import bfd_pkg::*; #(
    parameter int QueueDepth = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [3:0]  i_command,
    input  wire logic [2:0]  i_bit_offset,
    input  wire logic [15:0] i_window_head,
    input  wire logic [63:0] i_window_tail,
    input  wire logic [63:0] i_default_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      o_value,
    output logic [6:0]       o_bits_used,
    output logic             o_bad_code
);
    logic  q_valid, q_take;
    t_item q_item;
    t_res  res;

    bfd_front #(.Depth(QueueDepth)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_command, .i_bit_offset, .i_window_head, .i_window_tail, .i_default_value,
        .o_valid(q_valid), .i_take(q_take), .o_item(q_item)
    );

    bfd_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_take(q_take), .i_item(q_item),
        .o_empty(empty), .i_pop(pop), .o_res(res)
    );

    assign o_value     = res.value;
    assign o_bits_used = res.bits_used;
    assign o_bad_code  = res.bad_code;
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for bitcoded_field_decoder_core: directed and random field beats,
// checked against an in-bench decoder through a small scoreboard. Depends on bfd_pkg.
`default_nettype none

class field_scoreboard;
    typedef struct {
        logic [63:0] value;
        logic [6:0]  bits_used;
        logic        bad_code;
    } t_decoded;

    t_decoded pending[$];
    int errors = 0;
    int checked = 0;

    // Take n bits MSB-first from the 80-bit window starting at pos.
    static function logic [63:0] win_bits(logic [79:0] w, int pos, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            v = {v[62:0], (pos + i < 80) ? w[79 - pos - i] : 1'b0};
        end
        return v;
    endfunction

    static function logic [63:0] win_le(logic [79:0] w, int pos, int nbytes);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < nbytes; k++) begin
            v |= win_bits(w, pos + 8 * k, 8) << (8 * k);
        end
        return v;
    endfunction

    static function logic [63:0] sx(logic [63:0] v, int w);
        logic [63:0] m;
        m = 64'd1 << (w - 1);
        v &= (m << 1) - 1;
        return (v ^ m) - m;
    endfunction

    // Predict the decoded field for one beat and queue it.
    function void note_field(bfd_pkg::t_cmd cmd, logic [2:0] off, logic [15:0] head,
                             logic [63:0] tail, logic [63:0] dflt);
        t_decoded d;
        logic [79:0] w;
        logic [1:0] code;
        logic [63:0] b, w0, w1;
        int p, n;
        logic neg;
        w = {head, tail};
        p = off;
        code = 2'(win_bits(w, p, 2));
        d.value = '0;
        d.bits_used = '0;
        d.bad_code = 1'b0;
        case (cmd)
            bfd_pkg::CMD_BIT: begin d.value = win_bits(w, p, 1); d.bits_used = 7'd1; end
            bfd_pkg::CMD_BB: begin d.value = 64'(code); d.bits_used = 7'd2; end
            bfd_pkg::CMD_3B: begin d.value = win_bits(w, p, 3); d.bits_used = 7'd3; end
            bfd_pkg::CMD_4B: begin d.value = win_bits(w, p, 4); d.bits_used = 7'd4; end
            bfd_pkg::CMD_RC: begin d.value = win_bits(w, p, 8); d.bits_used = 7'd8; end
            bfd_pkg::CMD_RS: begin
                d.value = sx(win_le(w, p, 2), 16); d.bits_used = 7'd16;
            end
            bfd_pkg::CMD_RL: begin
                d.value = sx(win_le(w, p, 4), 32); d.bits_used = 7'd32;
            end
            bfd_pkg::CMD_RD: begin d.value = win_le(w, p, 8); d.bits_used = 7'd64; end
            bfd_pkg::CMD_BS: begin
                case (code)
                    2'd0: begin
                        d.value = sx(win_le(w, p + 2, 2), 16); d.bits_used = 7'd18;
                    end
                    2'd1: begin d.value = win_bits(w, p + 2, 8); d.bits_used = 7'd10; end
                    2'd2: d.bits_used = 7'd2;
                    default: begin d.value = 64'd256; d.bits_used = 7'd2; end
                endcase
            end
            bfd_pkg::CMD_BL: begin
                case (code)
                    2'd0: begin
                        d.value = sx(win_le(w, p + 2, 4), 32); d.bits_used = 7'd34;
                    end
                    2'd1: begin d.value = win_bits(w, p + 2, 8); d.bits_used = 7'd10; end
                    2'd2: d.bits_used = 7'd2;
                    default: begin d.bits_used = 7'd2; d.bad_code = 1'b1; end
                endcase
            end
            bfd_pkg::CMD_BD: begin
                d.bits_used = 7'd2;
                if (code == 2'd0) begin
                    d.value = win_le(w, p + 2, 8);
                    d.bits_used = 7'd66;
                end else if (code == 2'd1) begin
                    d.value = bfd_pkg::DOUBLE_ONE;
                end
            end
            bfd_pkg::CMD_DD: begin
                case (code)
                    2'd0: begin d.value = dflt; d.bits_used = 7'd2; end
                    2'd1: begin
                        w0 = win_le(w, p + 2, 4);
                        d.value = {dflt[63:32], w0[31:0]};
                        d.bits_used = 7'd34;
                    end
                    2'd2: begin
                        w0 = win_le(w, p + 2, 2);
                        w1 = win_le(w, p + 18, 4);
                        d.value = {dflt[63:48], w0[15:0], w1[31:0]};
                        d.bits_used = 7'd50;
                    end
                    default: begin d.value = win_le(w, p + 2, 8); d.bits_used = 7'd66; end
                endcase
            end
            bfd_pkg::CMD_MC, bfd_pkg::CMD_UMC: begin
                b = '0;
                neg = 1'b0;
                for (n = 0; n < 8; n++) begin
                    b = win_bits(w, p + 8 * n, 8);
                    if (!b[7] || n == 7) break;
                    d.value |= (b & 64'h7F) << (7 * n);
                end
                if (cmd == bfd_pkg::CMD_MC && b[6]) begin
                    neg = 1'b1;
                    b &= 64'h3F;
                end
                d.value |= (b & 64'h7F) << (7 * n);
                d.bits_used = 7'(8 * (n + 1));
                if (neg) d.value = -d.value;
            end
            bfd_pkg::CMD_MS: begin
                w0 = win_le(w, p, 2);
                if (w0[15]) begin
                    w1 = win_le(w, p + 16, 2);
                    d.value = (w0 & 64'h7FFF) | ((w1 & 64'h7FFF) << 15);
                    d.bits_used = 7'd32;
                end else begin
                    d.value = w0;
                    d.bits_used = 7'd16;
                end
            end
            default: ;
        endcase
        pending.push_back(d);
    endfunction

    function void report(string what);
        errors++;
        $display("mismatch #%0d at %0t: %s", errors, $realtime, what);
    endfunction

    // Compare one popped beat with the oldest prediction.
    function void check_field(logic [63:0] value, logic [6:0] bits_used, logic bad_code);
        t_decoded d;
        if (pending.size() == 0) begin
            report($sformatf("unexpected beat value=%h", value));
            return;
        end
        d = pending.pop_front();
        checked++;
        if (value !== d.value)
            report($sformatf("value %h, want %h", value, d.value));
        if (bits_used !== d.bits_used)
            report($sformatf("bits_used %0d, want %0d", bits_used, d.bits_used));
        if (bad_code !== d.bad_code)
            report($sformatf("bad_code %b, want %b", bad_code, d.bad_code));
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    localparam int NumRandom = 1650;
    localparam int StallLimit = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [3:0]  i_command;
    logic [2:0]  i_bit_offset;
    logic [15:0] i_window_head;
    logic [63:0] i_window_tail;
    logic [63:0] i_default_value;
    logic        empty;
    logic        pop;
    logic [63:0] o_value;
    logic [6:0]  o_bits_used;
    logic        o_bad_code;

    field_scoreboard sb;
    logic quiet;          // no idling on either side while set
    int   idle_cycles;
    int   cmd_seen[16];

    bitcoded_field_decoder_core dut (
        .i_clk, .i_rst_n, .push, .full, .i_command, .i_bit_offset,
        .i_window_head, .i_window_tail, .i_default_value,
        .empty, .pop, .o_value, .o_bits_used, .o_bad_code
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Drive one beat and hold it until accepted; idle first at random.
    task automatic send_field(t_cmd cmd, logic [2:0] off, logic [15:0] head,
                              logic [63:0] tail, logic [63:0] dflt);
        while (!quiet && $urandom_range(99) < 7) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_bit_offset <= off;
        i_window_head <= head;
        i_window_tail <= tail;
        i_default_value <= dflt;
        do @(posedge i_clk); while (full);
        sb.note_field(cmd, off, head, tail, dflt);
        cmd_seen[cmd]++;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Build a window whose field at the offset is a modular run of nb bytes.
    task automatic send_modular(t_cmd cmd, int nb);
        logic [79:0] w;
        logic [63:0] r;
        logic [2:0]  off;
        int pos;
        r = rnd64();
        w = {$urandom, r[47:0]};
        off = 3'($urandom_range(7));
        for (int k = 0; k < 8; k++) begin
            pos = 79 - off - 8 * k;
            if (k < nb - 1) w[pos] = 1'b1;
            else if (k == nb - 1 && nb < 8) w[pos] = 1'b0;
        end
        send_field(cmd, off, w[79:64], w[63:0], rnd64());
    endtask

    // Force the two-bit prefix at the offset.
    task automatic send_coded(t_cmd cmd, logic [1:0] code, logic [2:0] off,
                              logic [15:0] head, logic [63:0] tail);
        logic [79:0] w;
        w = {head, tail};
        w[79 - off -: 2] = code;
        send_field(cmd, off, w[79:64], w[63:0], rnd64());
    endtask

    // Receiver: pop with random stalls, check at the rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= quiet || ($urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_field(o_value, o_bits_used, o_bad_code);
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("watchdog: no progress for %0d cycles", StallLimit);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        sb = new();
        quiet = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_command = '0;
        i_bit_offset = '0;
        i_window_head = '0;
        i_window_tail = '0;
        i_default_value = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, every prefix code, modular limits, undefined command.
        send_field(CMD_RD, 3'd0, 16'h0000, 64'h0, 64'h0);
        send_field(CMD_RD, 3'd7, 16'hFFFF, '1, '1);
        send_field(CMD_RS, 3'd0, 16'h0080, 64'h0, 64'h0);
        send_field(CMD_RL, 3'd5, 16'hFFFF, '1, '1);
        for (int k = 0; k < 4; k++) begin
            send_coded(CMD_BS, k[1:0], 3'd7, 16'hFFFF, '1);
            send_coded(CMD_BL, k[1:0], 3'd6, 16'h00FF, 64'h8000_0000_0000_0001);
            send_coded(CMD_BD, k[1:0], 3'd1, 16'hA5A5, '1);
        end
        for (int k = 0; k < 4; k++)
            send_coded(CMD_DD, k[1:0], 3'd7, 16'hFFFF, '1);
        send_field(CMD_MC, 3'd0, 16'hFFFF, '1, 64'h0);   // eighth byte still continues
        send_field(CMD_MC, 3'd0, 16'h40FF, 64'h0, 64'h0); // single negative byte
        send_field(CMD_UMC, 3'd7, 16'hFFFF, '1, 64'h0);
        send_field(CMD_MS, 3'd7, 16'h00FF, '1, 64'h0);
        send_field(CMD_NONE, 3'd4, 16'hFFFF, '1, '1);

        // Random: half prefix-coded and modular fields, half arbitrary, quiet stretch in middle.
        for (int i = 0; i < NumRandom; i++) begin
            quiet = (i >= 600 && i < 900);
            c = t_cmd'($urandom_range(15));
            case ($urandom_range(3))
                0: send_modular($urandom_range(1) ? CMD_MC : CMD_UMC, $urandom_range(1, 8));
                1: send_coded($urandom_range(1) ? CMD_DD : t_cmd'($urandom_range(8, 11)),
                              2'($urandom_range(3)), 3'($urandom_range(7)),
                              16'($urandom), rnd64());
                default: send_field(c, 3'($urandom_range(7)), 16'($urandom),
                                    rnd64(), rnd64());
            endcase
        end
        quiet = 1'b0;
        push <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("covered %0d fields over all %0d commands, modular runs up to 8 bytes",
                 sb.checked, 16);
        $display("bad bitlong codes and undefined commands included; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
